// ===== rtl/swept_aabb_collision_defines.svh =====
// Assertion macros shared by the swept box collision RTL.
// No dependencies.
`ifndef SWEPT_AABB_COLLISION_DEFINES_SVH
`define SWEPT_AABB_COLLISION_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define SAC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sac_pkg.sv =====
// Shared types and constants for the swept box collision block.
// No dependencies.
package sac_pkg;
  localparam int CoordBits = 32;
  localparam int FracBits  = 16;
  localparam int FtBits    = 31;
  localparam int QDepth    = 2;
  localparam logic signed [CoordBits-1:0] SMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] SMin = {1'b1, {(CoordBits-1){1'b0}}};
  localparam logic [FtBits-1:0] FrameTimeReset = FtBits'(1092);
  localparam logic [0:0] RegFrameTime = 1'b0;

  typedef logic signed [CoordBits-1:0] coord_t;

  // Item as classified by the front end.
  typedef struct packed {
    coord_t      la;
    coord_t      ha;
    coord_t      lb;
    coord_t      hb;
    logic signed [CoordBits+1:0] rv;
    coord_t      pen;
    logic        apart;
    logic        last;
  } job_t;

  typedef struct packed {
    logic   hit;
    logic   already_overlapping;
    coord_t intersect_time;
    logic [1:0] contact_axis;
    coord_t penetration;
  } res_t;
endpackage

// ===== rtl/sac_if.sv =====
// Valid/ready channel interfaces for the swept box collision block.
// Depends on sac_pkg.
interface sac_in_if (input logic clk);
  logic valid;
  logic ready;
  sac_pkg::coord_t low_a, high_a, low_b, high_b, vel_a, vel_b;
  logic final_axis;
  modport source (output valid, low_a, high_a, low_b, high_b, vel_a, vel_b,
                  final_axis, input ready);
  modport sink (input valid, low_a, high_a, low_b, high_b, vel_a, vel_b,
                final_axis, output ready);
endinterface

interface sac_out_if (input logic clk);
  logic valid;
  logic ready;
  logic hit;
  logic already_overlapping;
  sac_pkg::coord_t intersect_time;
  logic [1:0] contact_axis;
  sac_pkg::coord_t penetration;
  modport source (output valid, hit, already_overlapping, intersect_time,
                  contact_axis, penetration, input ready);
  modport sink (input valid, hit, already_overlapping, intersect_time,
                contact_axis, penetration, output ready);
endinterface

// ===== rtl/sac_front.sv =====
// Front end: takes axis items, computes static depth and relative velocity.
// Depends on sac_pkg and sac_if.
module sac_front (
  input  logic          rst,
  sac_in_if.sink        in_ch,
  output logic          push,
  output sac_pkg::job_t push_job,
  input  logic          q_full
);
  localparam int CoordBits_p = sac_pkg::CoordBits;
  logic signed [CoordBits_p+2:0] c, d, ac, half;
  sac_pkg::coord_t pen;

  always_comb begin
    c = ((CoordBits_p+3)'(in_ch.low_b) + (CoordBits_p+3)'(in_ch.high_b))
      - ((CoordBits_p+3)'(in_ch.low_a) + (CoordBits_p+3)'(in_ch.high_a));
    ac = c[CoordBits_p+2] ? -c : c;
    d = ((CoordBits_p+3)'(in_ch.high_a) - (CoordBits_p+3)'(in_ch.low_a))
      + ((CoordBits_p+3)'(in_ch.high_b) - (CoordBits_p+3)'(in_ch.low_b)) - ac;
    // truncate toward zero
    half = (d + $signed((CoordBits_p+3)'(d[CoordBits_p+2]))) >>> 1;
    if (half > (CoordBits_p+3)'(sac_pkg::SMax)) pen = sac_pkg::SMax;
    else if (half < (CoordBits_p+3)'(sac_pkg::SMin)) pen = sac_pkg::SMin;
    else pen = half[CoordBits_p-1:0];
  end

  assign in_ch.ready = !q_full && !rst;
  assign push = in_ch.valid && in_ch.ready;

  always_comb begin
    push_job.la = in_ch.low_a;
    push_job.ha = in_ch.high_a;
    push_job.lb = in_ch.low_b;
    push_job.hb = in_ch.high_b;
    push_job.rv = (CoordBits_p+2)'(in_ch.vel_b) - (CoordBits_p+2)'(in_ch.vel_a)
                + (CoordBits_p+2)'(1);
    push_job.pen = pen;
    push_job.apart = (in_ch.high_a < in_ch.low_b) || (in_ch.low_a > in_ch.high_b);
    push_job.last = in_ch.final_axis;
  end
endmodule

// ===== rtl/sac_queue.sv =====
// Small FIFO of classified items between front and back ends.
// Depends on sac_pkg and swept_aabb_collision_defines.svh.
`include "swept_aabb_collision_defines.svh"
module sac_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sac_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output sac_pkg::job_t head
);
  sac_pkg::job_t slots [sac_pkg::QDepth];
  logic [$clog2(sac_pkg::QDepth)-1:0] wp, rp;
  logic [$clog2(sac_pkg::QDepth):0] cnt;

  assign full = cnt == ($clog2(sac_pkg::QDepth)+1)'(sac_pkg::QDepth);
  assign not_empty = cnt != '0;
  assign head = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_job;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + ($clog2(sac_pkg::QDepth)+1)'(push) - ($clog2(sac_pkg::QDepth)+1)'(pop);
    end
  end

  `SAC_ASSERT_IMP(a_no_overflow, push, !full, "queue push while full")
  `SAC_ASSERT_IMP(a_no_underflow, pop, not_empty, "queue pop while empty")
  `SAC_ASSERT_IMP(a_cnt_range, 1'b1, cnt <= ($clog2(sac_pkg::QDepth)+1)'(sac_pkg::QDepth),
                  "queue count out of range")
endmodule

// ===== rtl/sac_div.sv =====
// Radix-2 restoring divider: saturated signed Q quotient, truncated to zero.
// Depends on sac_pkg.
module sac_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic signed [sac_pkg::CoordBits+1:0] num,
  input  logic signed [sac_pkg::CoordBits+1:0] den,
  output logic            done,
  output sac_pkg::coord_t quo
);
  localparam int NB = sac_pkg::CoordBits + 2 + sac_pkg::FracBits;
  localparam int CW = $clog2(NB + 1);
  logic [NB-1:0] dvd, q;
  logic [sac_pkg::CoordBits+1:0] dsr;
  logic [sac_pkg::CoordBits+2:0] rem, trial;
  logic [CW-1:0] cnt;
  logic busy, neg;

  always_comb trial = {rem[sac_pkg::CoordBits+1:0], dvd[NB-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NB);
        neg <= num[sac_pkg::CoordBits+1] ^ den[sac_pkg::CoordBits+1];
        dvd <= {(num[sac_pkg::CoordBits+1] ? -num : num), {sac_pkg::FracBits{1'b0}}};
        dsr <= den[sac_pkg::CoordBits+1] ? -den : den;
        rem <= '0;
        q <= '0;
      end else if (busy) begin
        dvd <= dvd << 1;
        if (!trial[sac_pkg::CoordBits+2]) begin
          rem <= trial;
          q <= {q[NB-2:0], 1'b1};
        end else begin
          rem <= {rem[sac_pkg::CoordBits+1:0], dvd[NB-1]};
          q <= {q[NB-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) quo = (q >= NB'({1'b1, {(sac_pkg::CoordBits-1){1'b0}}})) ? sac_pkg::SMin
                   : -(q[sac_pkg::CoordBits-1:0]);
    else quo = (q > NB'(sac_pkg::SMax)) ? sac_pkg::SMax : q[sac_pkg::CoordBits-1:0];
  end
endmodule

// ===== rtl/sac_back.sv =====
// Back end: slab sweep with shared divider, multiply, result register.
// Depends on sac_pkg, sac_if, sac_div and swept_aabb_collision_defines.svh.
`include "swept_aabb_collision_defines.svh"
module sac_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  sac_pkg::job_t   head,
  output logic            pop,
  input  logic [sac_pkg::FtBits-1:0] frame_time,
  input  logic            ft_write,
  sac_out_if.source       out_ch
);
  localparam int W = sac_pkg::CoordBits;
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_PREP = 7'b0000010, S_DIV1 = 7'b0000100,
    S_DIV2 = 7'b0001000, S_CHK = 7'b0010000, S_MUL = 7'b0100000,
    S_DONE = 7'b1000000
  } st_t;
  st_t st;

  sac_pkg::job_t j;
  logic [1:0] axis_count, least_depth_axis, sweep_axis;
  logic overlap_so_far, sweep_rejected;
  sac_pkg::coord_t least_depth, t_enter, t_exit, earliest_contact, sweep_depth;
  logic need_enter, need_exit;
  logic signed [W+1:0] n_enter, n_exit;
  logic div_start, div_done;
  logic signed [W+1:0] div_num;
  sac_pkg::coord_t quo;
  logic [2*W+1:0] prod;
  logic prod_neg;
  logic [1:0] axis;

  sac_div u_div (.clk, .rst, .start(div_start), .num(div_num), .den(j.rv),
                 .done(div_done), .quo);

  assign axis = axis_count;
  assign pop = (st == S_IDLE) && not_empty && !(out_ch.valid && !out_ch.ready);

  // slab entry/exit selection depends on sign of rv
  always_comb begin
    if (j.rv <= 0) begin
      need_enter = j.ha < j.lb;
      n_enter = (W+2)'(j.ha) - (W+2)'(j.lb);
      need_exit = j.hb > j.la;
      n_exit = (W+2)'(j.la) - (W+2)'(j.hb);
    end else begin
      need_enter = j.hb < j.la;
      n_enter = (W+2)'(j.la) - (W+2)'(j.hb);
      need_exit = j.ha > j.lb;
      n_exit = (W+2)'(j.ha) - (W+2)'(j.lb);
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num = n_enter;
    if (st == S_PREP && need_enter) div_start = 1'b1;
    if (st == S_PREP && !need_enter && need_exit) begin
      div_start = 1'b1;
      div_num = n_exit;
    end
    if (st == S_DIV1 && div_done && need_exit) begin
      div_start = 1'b1;
      div_num = n_exit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out_ch.valid <= 1'b0;
      axis_count <= '0;
      overlap_so_far <= 1'b1;
      least_depth <= sac_pkg::SMax;
      least_depth_axis <= '0;
      t_enter <= '0;
      t_exit <= W'(sac_pkg::FrameTimeReset);
      earliest_contact <= W'(sac_pkg::FrameTimeReset);
      sweep_axis <= '0;
      sweep_depth <= '0;
      sweep_rejected <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (ft_write && axis_count == '0 && overlap_so_far && !sweep_rejected &&
          t_enter == '0 && least_depth == sac_pkg::SMax) begin
        t_exit <= W'(frame_time);
        earliest_contact <= W'(frame_time);
      end
      case (st)
        S_IDLE: begin
          if (pop) begin
            j <= head;
            if (head.apart) overlap_so_far <= 1'b0;
            if (head.pen < least_depth) begin
              least_depth <= head.pen;
              least_depth_axis <= axis;
            end
            st <= S_PREP;
          end
        end
        S_PREP: begin
          if (sweep_rejected) st <= S_DONE;
          else if ((j.rv <= 0 && j.hb < j.la) || (j.rv > 0 && j.lb > j.ha)) begin
            sweep_rejected <= 1'b1;
            st <= S_DONE;
          end else if (need_enter) st <= S_DIV1;
          else if (need_exit) st <= S_DIV2;
          else st <= S_CHK;
        end
        S_DIV1: begin
          if (div_done) begin
            if (quo > t_enter) t_enter <= quo;
            st <= need_exit ? S_DIV2 : S_CHK;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            if (quo < t_exit) t_exit <= quo;
            st <= S_CHK;
          end
        end
        S_CHK: begin
          if (t_enter > t_exit) begin
            sweep_rejected <= 1'b1;
            st <= S_DONE;
          end else if (t_enter < earliest_contact && t_enter > 0) begin
            earliest_contact <= t_enter;
            sweep_axis <= axis;
            prod_neg <= j.rv[W+1] ^ ((W+1)'(t_exit) < (W+1)'(t_enter));
            prod <= (2*W+2)'(j.rv[W+1] ? -j.rv : j.rv)
                  * (2*W+2)'(((W+1)'(t_exit) - (W+1)'(t_enter)));
            st <= S_MUL;
          end else st <= S_DONE;
        end
        S_MUL: begin
          if (prod_neg)
            sweep_depth <= ((prod >> sac_pkg::FracBits) >= (2*W+2)'(sac_pkg::SMax) + 1)
                           ? sac_pkg::SMin : -W'(prod >> sac_pkg::FracBits);
          else
            sweep_depth <= ((prod >> sac_pkg::FracBits) > (2*W+2)'(sac_pkg::SMax))
                           ? sac_pkg::SMax : W'(prod >> sac_pkg::FracBits);
          st <= S_DONE;
        end
        S_DONE: begin
          st <= S_IDLE;
          if (!j.last) begin
            if (axis_count < 2'd2) axis_count <= axis_count + 2'd1;
          end else begin
            out_ch.valid <= 1'b1;
            out_ch.hit <= overlap_so_far || !sweep_rejected;
            out_ch.already_overlapping <= overlap_so_far;
            out_ch.intersect_time <= (!overlap_so_far && !sweep_rejected) ? t_enter : '0;
            out_ch.contact_axis <= overlap_so_far ? least_depth_axis
                                 : (!sweep_rejected ? sweep_axis : 2'd0);
            out_ch.penetration <= overlap_so_far ? least_depth
                                : (!sweep_rejected ? sweep_depth : '0);
            axis_count <= '0;
            overlap_so_far <= 1'b1;
            least_depth <= sac_pkg::SMax;
            least_depth_axis <= '0;
            t_enter <= '0;
            t_exit <= W'(frame_time);
            earliest_contact <= W'(frame_time);
            sweep_axis <= '0;
            sweep_depth <= '0;
            sweep_rejected <= 1'b0;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `SAC_ASSERT_IMP(a_one_hot, 1'b1, $onehot(st), "state not one-hot")
  `SAC_ASSERT_NEXT(a_pop_prep, pop, st == S_PREP, "pop did not start sweep")
  `SAC_ASSERT_IMP(a_axis_max, 1'b1, axis_count <= 2'd2, "axis count overrun")
endmodule

// ===== rtl/swept_aabb_collision.sv =====
// Swept 3D box collision test, one axis per item, one result per test.
// From a final item to its result, the longest path holds two waits on the shared
// radix-2 divider (entry and exit). The back end finishes one item before it
// takes the next; a two-item queue takes new items while the back end divides.
// Reset (rst, synchronous) clears the test state; frame_time returns to 1092.
// Depends on sac_pkg, sac_if, sac_front, sac_queue, sac_back.
module swept_aabb_collision (
  input  logic        clk,
  input  logic        rst,
  sac_in_if.sink      in_ch,
  sac_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [sac_pkg::FtBits-1:0] frame_time, frame_time_next;
  logic ft_write, push, q_full, pop, not_empty;
  sac_pkg::job_t push_job, head;

  // APB: single register at word address zero
  assign pready = 1'b1;
  assign ft_write = psel && penable && pwrite && paddr[1:0] == 2'b00
                    && sac_pkg::RegFrameTime == 1'b0;
  assign prdata = {1'b0, frame_time};

  // back end sees the value being written, so an idle test reloads at once
  assign frame_time_next = ft_write ? pwdata[sac_pkg::FtBits-1:0] : frame_time;

  always_ff @(posedge clk) begin
    if (rst) frame_time <= sac_pkg::FrameTimeReset;
    else frame_time <= frame_time_next;
  end

  sac_front u_front (.rst, .in_ch, .push, .push_job, .q_full);
  sac_queue u_queue (.clk, .rst, .push, .push_job, .full(q_full), .pop,
                     .not_empty, .head);
  sac_back u_back (.clk, .rst, .not_empty, .head, .pop, .frame_time(frame_time_next),
                   .ft_write, .out_ch);
endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the swept 3D box collision block.
// Depends on sac_pkg, sac_if and the swept_aabb_collision RTL.
`timescale 1ns / 1ps

module tb;
  localparam longint CMax = 64'sh7FFF_FFFF;
  localparam longint CMin = -64'sh8000_0000;
  localparam int DrainCycles = 150;    // worst item latency plus margin
  localparam int StallLimit = 6000;    // cycles with no item moving

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  sac_in_if in_ch (clk);
  sac_out_if out_ch (clk);

  swept_aabb_collision dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: a private copy of the block's per-test accumulators.
  longint frame_len;
  int     axis_idx;
  bit     all_overlap;
  longint min_depth;
  int     min_depth_axis;
  longint enter_t, exit_t, first_touch;
  int     touch_axis;
  longint touch_depth;
  bit     swept_out;

  sac_pkg::res_t expected_reports[$];
  int     fail_count = 0;
  bit     no_idle = 1'b0;          // when set, neither side inserts gaps

  function automatic longint unsigned umag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint clamp_signed(bit neg, longint unsigned m);
    if (neg) return m >= 64'h8000_0000 ? CMin : -longint'(m);
    return m > 64'h7FFF_FFFF ? CMax : longint'(m);
  endfunction

  // Fixed-point quotient; a zero divisor acts as plus zero.
  function automatic longint fx_div(longint num, longint den);
    longint unsigned ud;
    ud = umag(den);
    if (ud == 0) return num == 0 ? 0 : (num < 0 ? CMin : CMax);
    return clamp_signed((num < 0) != (den < 0), (umag(num) << sac_pkg::FracBits) / ud);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned p;
    p = umag(a) * umag(b);
    return clamp_signed((a < 0) != (b < 0), p >> sac_pkg::FracBits);
  endfunction

  function automatic void clear_accum();
    axis_idx = 0;
    all_overlap = 1'b1;
    min_depth = CMax;
    min_depth_axis = 0;
    enter_t = 0;
    exit_t = frame_len;
    first_touch = frame_len;
    touch_axis = 0;
    touch_depth = 0;
    swept_out = 1'b0;
  endfunction

  function automatic void slab_sweep(longint la, longint ha, longint lb, longint hb,
                                     longint rv, int ax);
    longint q;
    if (swept_out) return;
    if (rv <= 0) begin
      if (hb < la) begin swept_out = 1'b1; return; end
      if (ha < lb) begin q = fx_div(ha - lb, rv); if (q > enter_t) enter_t = q; end
      if (hb > la) begin q = fx_div(la - hb, rv); if (q < exit_t) exit_t = q; end
    end else begin
      if (lb > ha) begin swept_out = 1'b1; return; end
      if (hb < la) begin q = fx_div(la - hb, rv); if (q > enter_t) enter_t = q; end
      if (ha > lb) begin q = fx_div(ha - lb, rv); if (q < exit_t) exit_t = q; end
    end
    if (enter_t > exit_t) swept_out = 1'b1;
    else if (enter_t < first_touch && enter_t > 0) begin
      first_touch = enter_t;
      touch_axis = ax;
      touch_depth = fx_mul(rv, exit_t - enter_t);
    end
  endfunction

  // Folds one axis into the accumulators; returns 1 with a report on the last axis.
  function automatic bit fold_axis(sac_pkg::coord_t la_i, sac_pkg::coord_t ha_i,
                                   sac_pkg::coord_t lb_i, sac_pkg::coord_t hb_i,
                                   sac_pkg::coord_t va_i, sac_pkg::coord_t vb_i,
                                   logic last, output sac_pkg::res_t rep);
    longint la, ha, lb, hb, c, d, pen, rv;
    la = la_i; ha = ha_i; lb = lb_i; hb = hb_i;
    rep = '0;
    if (ha < lb || la > hb) all_overlap = 1'b0;
    c = (lb + hb) - (la + ha);
    d = (ha - la) + (hb - lb) - (c < 0 ? -c : c);
    pen = d / 2;
    if (pen > CMax) pen = CMax;
    if (pen < CMin) pen = CMin;
    if (pen < min_depth) begin
      min_depth = pen;
      min_depth_axis = axis_idx;
    end
    rv = longint'(vb_i) - longint'(va_i) + 1;
    slab_sweep(la, ha, lb, hb, rv, axis_idx);
    if (!last) begin
      if (axis_idx < 2) axis_idx++;
      return 1'b0;
    end
    if (all_overlap) begin
      rep.hit = 1'b1;
      rep.already_overlapping = 1'b1;
      rep.contact_axis = min_depth_axis[1:0];
      rep.penetration = min_depth[31:0];
    end else if (!swept_out) begin
      rep.hit = 1'b1;
      rep.intersect_time = enter_t[31:0];
      rep.contact_axis = touch_axis[1:0];
      rep.penetration = touch_depth[31:0];
    end
    clear_accum();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Sends one axis item and records its expected report, if any.
  task automatic send_axis(sac_pkg::coord_t la, sac_pkg::coord_t ha, sac_pkg::coord_t lb,
                           sac_pkg::coord_t hb, sac_pkg::coord_t va, sac_pkg::coord_t vb,
                           logic last);
    int gap;
    sac_pkg::res_t rep;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.low_a <= la; in_ch.high_a <= ha;
    in_ch.low_b <= lb; in_ch.high_b <= hb;
    in_ch.vel_a <= va; in_ch.vel_b <= vb;
    in_ch.final_axis <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (fold_axis(la, ha, lb, hb, va, vb, last, rep)) expected_reports.push_back(rep);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_input();
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Register write, only with the block idle; items that yield no report
  // may still be in the divider, hence the extra wait.
  task automatic write_frame_time(logic [30:0] val);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 2'd0; pwdata <= {1'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    frame_len = val;
    if (axis_idx == 0 && all_overlap && !swept_out && enter_t == 0 && min_depth == CMax) begin
      exit_t = frame_len;
      first_touch = frame_len;
    end
  endtask

  function automatic sac_pkg::coord_t rnd_coord(int kind);
    case (kind)
      0: return sac_pkg::coord_t'($urandom());
      1: return sac_pkg::coord_t'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      default: begin
        case ($urandom_range(0, 3))
          0: return sac_pkg::SMax;
          1: return sac_pkg::SMin;
          2: return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // One random axis: mostly nearby boxes with speeds that can close the gap
  // within a frame, some full-range noise and some field extremes.
  task automatic send_random_axis(logic last);
    sac_pkg::coord_t la, lb, va, vb;
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      la = rnd_coord(1);
      lb = rnd_coord(1);
      va = sac_pkg::coord_t'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      vb = sac_pkg::coord_t'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      send_axis(la, la + sac_pkg::coord_t'($urandom_range(0, 32'h8000)), lb,
                lb + sac_pkg::coord_t'($urandom_range(0, 32'h8000)), va, vb, last);
    end else if (r < 92) begin
      send_axis(rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0),
                rnd_coord(0), rnd_coord(0), last);
    end else begin
      send_axis(rnd_coord(2), rnd_coord(2), rnd_coord(2), rnd_coord(2),
                rnd_coord(2), rnd_coord(0), last);
    end
  endtask

  // A random test: usually three axes, sometimes cut short or run long.
  task automatic send_random_test(output int n);
    int r;
    r = $urandom_range(0, 99);
    n = r < 80 ? 3 : (r < 90 ? $urandom_range(1, 2) : $urandom_range(4, 6));
    for (int i = 0; i < n; i++) send_random_axis(i == n - 1);
  endtask

  task automatic run_random(int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      send_random_test(n);
      sent += n;
    end
  endtask

  // Extremes, static hit, swept hit, miss, zero relative speed, short,
  // long and inverted-bound tests.
  task automatic test_directed();
    // static overlap, least depth on y
    send_axis(0, 32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000, 0, 0, 0);
    send_axis(0, 32'sh0002_0000, 32'sh0001_C000, 32'sh0003_0000, 0, 0, 0);
    send_axis(0, 32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000, 0, 0, 1);
    // swept contact on x: B closes fast from the right
    send_axis(0, 32'sh0001_0000, 32'sh0001_0100, 32'sh0002_0000, 0,
              -32'sh0100_0000, 0);
    send_axis(0, 32'sh0001_0000, 0, 32'sh0001_0000, 0, 0, 0);
    send_axis(0, 32'sh0001_0000, 0, 32'sh0001_0000, 0, 0, 1);
    // miss: far apart, no motion
    send_axis(0, 32'sh0001_0000, 32'sh0010_0000, 32'sh0011_0000, 0, 0, 0);
    send_axis(0, 1, 0, 1, 0, 0, 0);
    send_axis(0, 1, 0, 1, 0, 0, 1);
    // relative speed zero after the one-LSB bias
    send_axis(0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1, 0, 0);
    send_axis(-32'sh0003_0000, -32'sh0002_0000, 0, 32'sh0001_0000, 1, 0, 1);
    // field extremes
    send_axis(sac_pkg::SMin, sac_pkg::SMax, sac_pkg::SMin, sac_pkg::SMax,
              sac_pkg::SMin, sac_pkg::SMax, 0);
    send_axis(sac_pkg::SMax, sac_pkg::SMin, sac_pkg::SMax, sac_pkg::SMin,
              sac_pkg::SMax, sac_pkg::SMin, 0);
    send_axis(sac_pkg::SMin, sac_pkg::SMin, sac_pkg::SMax, sac_pkg::SMax,
              sac_pkg::SMax, sac_pkg::SMin, 1);
    send_axis(sac_pkg::SMax, sac_pkg::SMax, sac_pkg::SMin, sac_pkg::SMin,
              sac_pkg::SMin, sac_pkg::SMax, 1);   // short test
    // long test: axes past z fold into z
    for (int i = 0; i < 5; i++)
      send_axis(-32'sh0000_8000, 32'sh0000_8000, 0, 32'sh0001_0000, 0, 0, i == 4);
    // inverted bounds taken as given
    send_axis(32'sh0001_0000, 0, 32'sh0002_0000, 32'sh0000_8000, 5, -7, 1);
  endtask

  task automatic test_frame_extremes();
    write_frame_time(31'd1);
    run_random(40);
    write_frame_time(31'h7FFF_FFFF);
    run_random(40);
    write_frame_time(31'($urandom()));
    run_random(40);
  endtask

  task automatic test_back_to_back();
    write_frame_time(31'h0001_0000);
    no_idle = 1'b1;
    run_random(60);
    no_idle = 1'b0;
  endtask

  // Sender holds off after every third test until every report is back, then resumes.
  task automatic test_drain_pause();
    int n;
    write_frame_time(31'd1092);
    for (int k = 0; k < 10; k++) begin
      send_random_test(n);
      if (k % 3 == 2) wait_drained();
    end
    run_random(180);
  endtask

  // Report sink: compare each report, then pick the next ready level.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected report: hit=%0b ovl=%0b t=%0d ax=%0d pen=%0d", $time,
                 out_ch.hit, out_ch.already_overlapping, out_ch.intersect_time,
                 out_ch.contact_axis, out_ch.penetration);
        fail_count++;
      end else begin
        automatic sac_pkg::res_t want = expected_reports.pop_front();
        if (out_ch.hit !== want.hit) begin
          $display("%0t hit: expected %0b got %0b", $time, want.hit, out_ch.hit);
          fail_count++;
        end
        if (out_ch.already_overlapping !== want.already_overlapping) begin
          $display("%0t already_overlapping: expected %0b got %0b", $time,
                   want.already_overlapping, out_ch.already_overlapping);
          fail_count++;
        end
        if (out_ch.intersect_time !== want.intersect_time) begin
          $display("%0t intersect_time: expected %0d got %0d", $time,
                   want.intersect_time, out_ch.intersect_time);
          fail_count++;
        end
        if (out_ch.contact_axis !== want.contact_axis) begin
          $display("%0t contact_axis: expected %0d got %0d", $time,
                   want.contact_axis, out_ch.contact_axis);
          fail_count++;
        end
        if (out_ch.penetration !== want.penetration) begin
          $display("%0t penetration: expected %0d got %0d", $time,
                   want.penetration, out_ch.penetration);
          fail_count++;
        end
      end
    end
    if (no_idle) out_ch.ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 65) out_ch.ready <= 1'b1;
    else begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
                                              : $urandom_range(0, 2);
    end
  end

  // Watchdog: too long with no item moving on either channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    paddr <= '0; pwdata <= '0;
    in_ch.valid <= 1'b0; in_ch.final_axis <= 1'b0;
    in_ch.low_a <= '0; in_ch.high_a <= '0; in_ch.low_b <= '0;
    in_ch.high_b <= '0; in_ch.vel_a <= '0; in_ch.vel_b <= '0;
    frame_len = 1092;
    clear_accum();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_frame_extremes();
    test_back_to_back();
    test_drain_pause();

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
